@@ rtl/sbt_pkg.sv @@
package sbt_pkg;

  // Default depth of the queue between the lexer front and the result back end.
  localparam int SBT_QDEPTH = 4;

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_COMMENT  = 4'd1,
    M_STRING   = 4'd2,
    M_STR_ESC  = 4'd3,
    M_HASH     = 4'd4,
    M_CHARVAL  = 4'd5,
    M_SIGN     = 4'd6,
    M_NUMBER   = 4'd7,
    M_PIPE     = 4'd8,
    M_PIPE_ESC = 4'd9,
    M_SYMBOL   = 4'd10
  } mode_t;

  localparam logic [3:0] K_COMMENT = 4'd0;
  localparam logic [3:0] K_LPAREN  = 4'd1;
  localparam logic [3:0] K_RPAREN  = 4'd2;
  localparam logic [3:0] K_DOT     = 4'd3;
  localparam logic [3:0] K_QUOTE   = 4'd4;
  localparam logic [3:0] K_BQUOTE  = 4'd5;
  localparam logic [3:0] K_STRING  = 4'd6;
  localparam logic [3:0] K_CHAR    = 4'd7;
  localparam logic [3:0] K_NUMBER  = 4'd8;
  localparam logic [3:0] K_SYMBOL  = 4'd9;
  localparam logic [3:0] K_END     = 4'd10;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_BAD_ESC = 2'd1;
  localparam logic [1:0] E_BAD_CHR = 2'd2;
  localparam logic [1:0] E_OPEN    = 2'd3;

  // One result of the lexer.
  typedef struct packed {
    logic       is_value;
    logic [7:0] value_byte;
    logic [3:0] kind;
    logic [1:0] err;
  } res_t;

  // All results caused by one source byte, in order from slot 0.
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     slot;
  } bundle_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/sbt_front.sv @@
module sbt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  sbt_pkg::q_stat_t  q_stat,
  output logic              push_valid,
  output sbt_pkg::bundle_t  push_data
);

  typedef struct packed {
    sbt_pkg::mode_t mode;
    logic           hit;
    sbt_pkg::res_t  res;
  } idle_t;

  sbt_pkg::mode_t   mode_r, mode_nxt;
  logic [7:0]       held_sign_r, held_sign_nxt;
  sbt_pkg::bundle_t bnd;
  idle_t            fi;
  logic [7:0]       b;
  logic             accept;
  logic             digit_b;
  logic             is_stop;

  function automatic sbt_pkg::res_t mk(input logic isv, input logic [7:0] val,
                                       input logic [3:0] kind, input logic [1:0] err);
    sbt_pkg::res_t r;
    r.is_value   = isv;
    r.value_byte = val;
    r.kind       = kind;
    r.err        = err;
    return r;
  endfunction

  function automatic sbt_pkg::bundle_t put(input sbt_pkg::bundle_t bi, input sbt_pkg::res_t r);
    sbt_pkg::bundle_t bo;
    bo = bi;
    bo.slot[bi.cnt] = r;
    bo.cnt = bi.cnt + 2'd1;
    return bo;
  endfunction

  // Lexing a byte that starts a new token.
  function automatic idle_t from_idle(input logic [7:0] c);
    idle_t o;
    o.mode = sbt_pkg::M_IDLE;
    o.hit  = 1'b0;
    o.res  = mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE);
    case (c)
      8'h00: o.hit = 1'b1;
      8'h20, 8'h09, 8'h0D, 8'h0A: o.hit = 1'b0;
      8'h3B: o.mode = sbt_pkg::M_COMMENT;
      8'h28: begin
        o.hit = 1'b1;
        o.res.kind = sbt_pkg::K_LPAREN;
      end
      8'h29: begin
        o.hit = 1'b1;
        o.res.kind = sbt_pkg::K_RPAREN;
      end
      8'h2E: begin
        o.hit = 1'b1;
        o.res.kind = sbt_pkg::K_DOT;
      end
      8'h27: begin
        o.hit = 1'b1;
        o.res.kind = sbt_pkg::K_QUOTE;
      end
      8'h60: begin
        o.hit = 1'b1;
        o.res.kind = sbt_pkg::K_BQUOTE;
      end
      8'h22: o.mode = sbt_pkg::M_STRING;
      8'h23: o.mode = sbt_pkg::M_HASH;
      8'h2B, 8'h2D: o.mode = sbt_pkg::M_SIGN;
      8'h7C: begin
        o.hit  = 1'b1;
        o.res  = mk(1'b1, c, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE);
        o.mode = sbt_pkg::M_PIPE;
      end
      default: begin
        o.hit = 1'b1;
        if (c inside {[8'h30:8'h39]}) begin
          o.res  = mk(1'b1, c, sbt_pkg::K_NUMBER, sbt_pkg::E_NONE);
          o.mode = sbt_pkg::M_NUMBER;
        end else begin
          o.res  = mk(1'b1, c, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE);
          o.mode = sbt_pkg::M_SYMBOL;
        end
      end
    endcase
    return o;
  endfunction

  assign b          = in_tdata;
  assign in_tready  = !q_stat.full;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = accept && (bnd.cnt != 2'd0);
  assign push_data  = bnd;
  assign digit_b    = b inside {[8'h30:8'h39]};
  assign is_stop    = b inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h28, 8'h29, 8'h3B, 8'h22,
                                8'h27, 8'h60, 8'h7C, 8'h00};
  assign fi         = from_idle(b);

  always_comb begin
    logic [7:0] dec;
    logic       dec_ok;
    bnd           = '0;
    mode_nxt      = mode_r;
    held_sign_nxt = held_sign_r;
    dec_ok        = 1'b1;
    case (b)
      8'h61:   dec = 8'h07;
      8'h62:   dec = 8'h08;
      8'h74:   dec = 8'h09;
      8'h6E:   dec = 8'h0A;
      8'h76:   dec = 8'h0B;
      8'h66:   dec = 8'h0C;
      8'h72:   dec = 8'h0D;
      8'h22:   dec = 8'h22;
      8'h5C:   dec = 8'h5C;
      default: begin
        dec    = 8'h00;
        dec_ok = 1'b0;
      end
    endcase

    case (mode_r)
      sbt_pkg::M_COMMENT: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_COMMENT, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (b == 8'h0A) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_COMMENT, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_COMMENT, sbt_pkg::E_NONE));
        end
      end
      sbt_pkg::M_STRING: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_STRING, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (b == 8'h22) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_STRING, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (b == 8'h5C) begin
          mode_nxt = sbt_pkg::M_STR_ESC;
        end else begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_STRING, sbt_pkg::E_NONE));
        end
      end
      sbt_pkg::M_STR_ESC: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_STRING, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (!dec_ok) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_STRING, sbt_pkg::E_BAD_ESC));
          mode_nxt = sbt_pkg::M_IDLE;
        end else begin
          bnd = put(bnd, mk(1'b1, dec, sbt_pkg::K_STRING, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_STRING;
        end
      end
      sbt_pkg::M_HASH: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_CHAR, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (b == 8'h5C) begin
          mode_nxt = sbt_pkg::M_CHARVAL;
        end else begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_CHAR, sbt_pkg::E_BAD_CHR));
          mode_nxt = sbt_pkg::M_IDLE;
        end
      end
      sbt_pkg::M_CHARVAL: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_CHAR, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
        end else begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_CHAR, sbt_pkg::E_NONE));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_CHAR, sbt_pkg::E_NONE));
        end
        mode_nxt = sbt_pkg::M_IDLE;
      end
      sbt_pkg::M_SIGN: begin
        held_sign_nxt = 8'h00;
        if (digit_b) begin
          bnd = put(bnd, mk(1'b1, held_sign_r, sbt_pkg::K_NUMBER, sbt_pkg::E_NONE));
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_NUMBER, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_NUMBER;
        end else begin
          // A lone sign becomes the first byte of a plain symbol.
          bnd = put(bnd, mk(1'b1, held_sign_r, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
          if (!is_stop) begin
            bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
            mode_nxt = sbt_pkg::M_SYMBOL;
          end else begin
            bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
            mode_nxt = fi.mode;
            if (fi.hit) begin
              bnd = put(bnd, fi.res);
            end
          end
        end
      end
      sbt_pkg::M_NUMBER: begin
        if (digit_b) begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_NUMBER, sbt_pkg::E_NONE));
        end else begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_NUMBER, sbt_pkg::E_NONE));
          mode_nxt = fi.mode;
          if (fi.hit) begin
            bnd = put(bnd, fi.res);
          end
          if (fi.mode == sbt_pkg::M_SIGN) begin
            held_sign_nxt = b;
          end
        end
      end
      sbt_pkg::M_PIPE: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_SYMBOL, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (b == 8'h7C) begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else if (b == 8'h5C) begin
          mode_nxt = sbt_pkg::M_PIPE_ESC;
        end else begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
        end
      end
      sbt_pkg::M_PIPE_ESC: begin
        if (b == 8'h00) begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_SYMBOL, sbt_pkg::E_OPEN));
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_END, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_IDLE;
        end else begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
          mode_nxt = sbt_pkg::M_PIPE;
        end
      end
      sbt_pkg::M_SYMBOL: begin
        if (!is_stop) begin
          bnd = put(bnd, mk(1'b1, b, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
        end else begin
          bnd = put(bnd, mk(1'b0, 8'h00, sbt_pkg::K_SYMBOL, sbt_pkg::E_NONE));
          mode_nxt = fi.mode;
          if (fi.hit) begin
            bnd = put(bnd, fi.res);
          end
        end
      end
      default: begin
        mode_nxt = fi.mode;
        if (fi.hit) begin
          bnd = put(bnd, fi.res);
        end
        if (fi.mode == sbt_pkg::M_SIGN) begin
          held_sign_nxt = b;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sbt_pkg::M_IDLE;
      held_sign_r <= 8'h00;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      held_sign_r <= held_sign_nxt;
    end
  end

endmodule

@@ rtl/sbt_queue.sv @@
module sbt_queue #(
  parameter int DEPTH = sbt_pkg::SBT_QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  sbt_pkg::bundle_t  push_data,
  input  logic              pop,
  output sbt_pkg::bundle_t  pop_data,
  output sbt_pkg::q_stat_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sbt_pkg::bundle_t entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/sbt_back.sv @@
module sbt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sbt_pkg::q_stat_t  q_stat,
  input  sbt_pkg::bundle_t  pop_data,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [4:0]        out_tuser,
  output logic              out_tlast
);

  sbt_pkg::bundle_t cur_r, cur_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic [1:0]       idx_r, idx_nxt;
  sbt_pkg::res_t    res;
  logic             last;
  logic             out_accept;

  assign res        = cur_r.slot[idx_r];
  assign last       = (idx_r == cur_r.cnt - 2'd1);
  assign out_accept = out_tvalid && out_tready;
  assign out_tvalid = cur_valid_r;
  assign out_tdata  = {6'd0, res.err, res.value_byte};
  assign out_tuser  = {res.kind, res.is_value};
  assign out_tlast  = last;
  assign pop        = !q_stat.empty && (!cur_valid_r || (out_accept && last));

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_nxt       = pop_data;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (out_accept) begin
      if (last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

@@ rtl/sexpr_byte_tokenizer.sv @@
// Path: the results of a source byte are written into the queue as one bundle, then loaded
// into the back end's bundle register, from which they are offered on the output.
// Throughput: one source byte per cycle while results keep up; the output moves one result
// beat per cycle while out_tready is high, so a byte with two or three results takes as many beats.
// The front lexer state is updated once per accepted byte; the queue depth sets the slack.
// Reset: synchronous, active low; the lexer returns to idle and the queue and output empty.
module sexpr_byte_tokenizer #(
  parameter int QDEPTH = sbt_pkg::SBT_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Source byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  // Result stream, one result per beat.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_byte, [9:8] err_code, [15:10] zero
  output logic [4:0]  out_tuser,  // [0] is_value, [4:1] token_kind
  output logic        out_tlast   // last_of_run: last result caused by one source byte
);

  // The front classifies each source byte and collects all of its results into one
  // bundle. Bytes that cause no result (whitespace, opening quotes and escapes) leave
  // nothing in the queue.
  sbt_pkg::q_stat_t q_stat;
  sbt_pkg::bundle_t push_data;
  sbt_pkg::bundle_t pop_data;
  logic             push_valid;
  logic             pop;

  sbt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // The queue decouples the lexer from a stalled output.
  sbt_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .pop_data   (pop_data),
    .q_stat     (q_stat)
  );

  // The back end holds one bundle and sends its results one beat at a time. The next
  // bundle is loaded in the cycle the last beat of the current one is taken.
  sbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The front must never offer a bundle the queue cannot hold.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push_valid)
    else $error("bundle pushed into a full queue");

  // A waiting bundle always leads to a presented beat in the next cycle.
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |=> out_tvalid)
    else $error("queued results not presented");

  // Error beats are records: no value flag and a zero value byte.
  a_err_is_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[9:8] != sbt_pkg::E_NONE)) |->
      (!out_tuser[0] && (out_tdata[7:0] == 8'h00)))
    else $error("error code on a value beat");

endmodule
